### sv/gaussian_unsharp_sharpen_defines.svh
// assertion helpers for the sharpener
`ifndef GAUSSIAN_UNSHARP_SHARPEN_DEFINES_SVH
`define GAUSSIAN_UNSHARP_SHARPEN_DEFINES_SVH

// same-cycle implication
`define GUS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gus_pkg.sv
package gus_pkg;

    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int WEIGHT_MAX_W = 24;
    localparam int GEOM_W       = 12;
    localparam int WIDTH_W      = 14;
    localparam int ROW_W        = 16;
    localparam int PIX_W        = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D0   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D1   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D2   = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D4   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D5   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_W_D8   = 4'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [GEOM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [GEOM_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [7:0] HP_OFFSET  = 8'd128;
    localparam logic [8:0] OUT_OFFSET = 9'd170;
    localparam logic [8:0] PIX_MAX    = 9'd255;

    typedef enum logic [2:0] {
        W_D0,
        W_D1,
        W_D2,
        W_D4,
        W_D5,
        W_D8
    } wclass_t;

    localparam logic [WEIGHT_MAX_W-1:0] WGT_RESET [6] = '{
        24'd65535, 24'd52474, 24'd42021, 24'd26941, 24'd21574, 24'd11075
    };

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_ACC,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic shift;
        logic acc_clear;
        logic acc_step;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic tap_last;
        logic div_last;
        logic out_free;
    } sts_t;

    // weight class of a window tap from its squared distance to the centre
    function automatic wclass_t tap_class(input logic [2:0] r, input logic [2:0] c);
        logic [2:0] ar;
        logic [2:0] ac;
        logic [3:0] d;
        wclass_t    k;
        ar = (r > 3'd2) ? 3'(r - 3'd2) : 3'(3'd2 - r);
        ac = (c > 3'd2) ? 3'(c - 3'd2) : 3'(3'd2 - c);
        d  = 4'(ar * ar) + 4'(ac * ac);
        case (d)
            4'd0:    k = W_D0;
            4'd1:    k = W_D1;
            4'd2:    k = W_D2;
            4'd4:    k = W_D4;
            4'd5:    k = W_D5;
            default: k = W_D8;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] sharpen(input logic [7:0] orig, input logic [7:0] blur);
        logic [7:0] hp;
        logic [8:0] v;
        logic [8:0] o;
        hp = 8'(orig - blur + HP_OFFSET);
        v  = {1'b0, orig} + {1'b0, hp};
        if (v < OUT_OFFSET)
            o = '0;
        else if (9'(v - OUT_OFFSET) > PIX_MAX)
            o = PIX_MAX;
        else
            o = 9'(v - OUT_OFFSET);
        return o[7:0];
    endfunction

endpackage

### sv/gaussian_unsharp_sharpen.sv
// Streaming 5x5 unsharp-mask sharpener for RGB pixels in raster order. Each accepted
// item gets a row-store read and a window shift; one that yields a result then runs
// the tap loop (one tap a cycle on three shared 8-bit by weight multipliers), the
// bit-a-cycle divide by the weight sum and an output register load, which waits for
// out_ready while an older result is held. Results lag the input by two rows plus two
// pixels; send drain items (op = 1) after the last pixel to flush the frame. A new
// item is taken while a finished result still waits on out_ready. Writing the width
// or height restarts the frame; write registers only while the block is idle.
module gaussian_unsharp_sharpen #(
    parameter int MAX_WIDTH   = 2048,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gus_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gus_pkg::out_item_t              out_data,
    input  logic                            cfg_write,
    input  logic [gus_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gus_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gus_pkg::cmd_t cmd;
    gus_pkg::sts_t sts;

    gus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gus_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### sv/gus_ctrl.sv
`include "gaussian_unsharp_sharpen_defines.svh"

module gus_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gus_pkg::sts_t sts,
    output gus_pkg::cmd_t cmd
);

    gus_pkg::state_t state_reg;
    gus_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gus_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gus_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = gus_pkg::S_SHIFT;
            end
            gus_pkg::S_SHIFT:
            begin
                state_next = sts.emit ? gus_pkg::S_ACC : gus_pkg::S_IDLE;
            end
            gus_pkg::S_ACC:
            begin
                if (sts.tap_last)
                    state_next = gus_pkg::S_DIV;
            end
            gus_pkg::S_DIV:
            begin
                if (sts.div_last)
                    state_next = gus_pkg::S_DONE;
            end
            gus_pkg::S_DONE:
            begin
                if (sts.out_free)
                    state_next = gus_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gus_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gus_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            gus_pkg::S_SHIFT:
            begin
                cmd.shift     = 1'b1;
                cmd.acc_clear = sts.emit;
            end
            gus_pkg::S_ACC:
            begin
                cmd.acc_step = 1'b1;
            end
            gus_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            gus_pkg::S_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `GUS_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, state_reg != gus_pkg::S_IDLE, "input transfer did not start work")
    `GUS_ASSERT_SAME(a_load_free, cmd.load_out, sts.out_free, "result loaded over a waiting one")
    `GUS_ASSERT_NEXT(a_div_done, (state_reg == gus_pkg::S_DIV) && sts.div_last, state_reg == gus_pkg::S_DONE, "divide end missed")
    `GUS_ASSERT_SAME(a_acc_only, cmd.acc_step, !cmd.capture && !in_ready, "accumulate while idle")

endmodule

### sv/gus_dp.sv
module gus_dp #(
    parameter int MAX_WIDTH   = 2048,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gus_pkg::in_item_t                   in_data,
    output gus_pkg::out_item_t                  out_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_write,
    input  logic [gus_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gus_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  gus_pkg::cmd_t                       cmd,
    output gus_pkg::sts_t                       sts
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = gus_pkg::WIDTH_W;
    localparam int WSUM_W = WEIGHT_BITS + 5;
    localparam int SUM_W  = WEIGHT_BITS + 13;
    localparam int PROD_W = WEIGHT_BITS + 8;

    logic [gus_pkg::GEOM_W-1:0] width_reg;
    logic [gus_pkg::GEOM_W-1:0] height_reg;
    logic [WEIGHT_BITS-1:0]     weight_reg [6];

    logic [CW-1:0]               in_col_reg;
    logic [gus_pkg::ROW_W-1:0]   in_row_reg;
    logic [CW-1:0]               out_col_reg;
    logic [gus_pkg::GEOM_W-1:0]  out_row_reg;

    logic [gus_pkg::PIX_W-1:0] mem_rd_reg [4];
    logic [gus_pkg::PIX_W-1:0] px_reg;
    logic [1:0]                bank_reg;
    logic                      emit_reg;

    logic [gus_pkg::PIX_W-1:0] win_reg [5][5];

    logic [2:0]        tr_reg;
    logic [2:0]        tc_reg;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [WSUM_W-1:0] wsum_reg;
    logic [2:0]        dstep_reg;
    logic [7:0]        quot_reg [3];

    logic               out_valid_reg;
    gus_pkg::out_item_t out_reg;

    logic [WW-1:0]              w_eff;
    logic [gus_pkg::GEOM_W-1:0] h_eff;
    logic                       pixel;
    logic                       col_wrap;
    logic                       emit_now;
    logic [WEIGHT_BITS-1:0]     wtap;
    logic [gus_pkg::PIX_W-1:0]  tap;
    logic                       tap_in;
    logic [WW:0]                tx;
    logic [gus_pkg::GEOM_W:0]   ty;
    logic [SUM_W-1:0]           divisor;
    logic [gus_pkg::WEIGHT_MAX_W-1:0] cfg_ext;
    logic [gus_pkg::PIX_W-1:0]  centre;
    logic [7:0]                 orig [3];
    logic [7:0]                 blur [3];
    logic                       last;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg == '0) ? gus_pkg::GEOM_W'(1) : height_reg;
    end

    assign pixel    = (in_data.op == gus_pkg::OP_PIXEL)
                   && (in_row_reg < gus_pkg::ROW_W'(h_eff));
    assign col_wrap = (WW'(in_col_reg) + WW'(1)) >= w_eff;
    assign emit_now = (in_row_reg >= gus_pkg::ROW_W'(4))
                   || ((in_row_reg == gus_pkg::ROW_W'(3)) && (w_eff >= WW'(2)))
                   || ((in_row_reg == gus_pkg::ROW_W'(2)) && (WW'(in_col_reg) >= WW'(2)));
    assign cfg_ext  = gus_pkg::WEIGHT_MAX_W'(cfg_data);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gus_pkg::WIDTH_RESET;
            height_reg <= gus_pkg::HEIGHT_RESET;
            for (int i = 0; i < 6; i++)
                weight_reg[i] <= gus_pkg::WGT_RESET[i][WEIGHT_BITS-1:0];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gus_pkg::REG_WIDTH:  width_reg  <= cfg_data[gus_pkg::GEOM_W-1:0];
                gus_pkg::REG_HEIGHT: height_reg <= cfg_data[gus_pkg::GEOM_W-1:0];
                gus_pkg::REG_W_D0:   weight_reg[gus_pkg::W_D0] <= cfg_ext[WEIGHT_BITS-1:0];
                gus_pkg::REG_W_D1:   weight_reg[gus_pkg::W_D1] <= cfg_ext[WEIGHT_BITS-1:0];
                gus_pkg::REG_W_D2:   weight_reg[gus_pkg::W_D2] <= cfg_ext[WEIGHT_BITS-1:0];
                gus_pkg::REG_W_D4:   weight_reg[gus_pkg::W_D4] <= cfg_ext[WEIGHT_BITS-1:0];
                gus_pkg::REG_W_D5:   weight_reg[gus_pkg::W_D5] <= cfg_ext[WEIGHT_BITS-1:0];
                gus_pkg::REG_W_D8:   weight_reg[gus_pkg::W_D8] <= cfg_ext[WEIGHT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // row store: four banks, one per stored row
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [gus_pkg::PIX_W-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (cmd.capture)
            begin
                if (pixel && (in_row_reg[1:0] == 2'(b)))
                    mem[in_col_reg] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
                mem_rd_reg[b] <= mem[in_col_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg   <= pixel ? {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;
            bank_reg <= in_row_reg[1:0];
        end
    end

    // positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            emit_reg    <= 1'b0;
        end
        else if (cfg_write && ((cfg_index == gus_pkg::REG_WIDTH)
                            || (cfg_index == gus_pkg::REG_HEIGHT)))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cmd.capture)
        begin
            emit_reg <= emit_now;
            if (col_wrap)
            begin
                in_col_reg <= '0;
                if (in_row_reg != '1)
                    in_row_reg <= in_row_reg + 1'b1;
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
            end
        end
        else if (cmd.load_out)
        begin
            if (last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if ((WW'(out_col_reg) + WW'(1)) >= w_eff)
            begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + 1'b1;
            end
            else
            begin
                out_col_reg <= out_col_reg + 1'b1;
            end
        end
    end

    // 5x5 window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 5; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 4; c++)
                    win_reg[r][c] <= win_reg[r][c+1];
            for (int r = 0; r < 4; r++)
                win_reg[r][4] <= mem_rd_reg[2'(bank_reg + 2'(r))];
            win_reg[4][4] <= px_reg;
        end
    end

    // tap accumulate and divide
    assign tap  = win_reg[tr_reg][tc_reg];
    assign wtap = weight_reg[gus_pkg::tap_class(tr_reg, tc_reg)];
    assign tx   = (WW+1)'(out_col_reg) + (WW+1)'(tc_reg);
    assign ty   = (gus_pkg::GEOM_W+1)'(out_row_reg) + (gus_pkg::GEOM_W+1)'(tr_reg);
    assign tap_in = (tx >= (WW+1)'(2)) && (tx < ((WW+1)'(w_eff) + (WW+1)'(2)))
                 && (ty >= (gus_pkg::GEOM_W+1)'(2))
                 && (ty < ((gus_pkg::GEOM_W+1)'(h_eff) + (gus_pkg::GEOM_W+1)'(2)));
    assign divisor = SUM_W'(wsum_reg) << dstep_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            tr_reg    <= '0;
            tc_reg    <= '0;
            wsum_reg  <= '0;
            dstep_reg <= 3'd7;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                quot_reg[k] <= '0;
            end
        end
        else if (cmd.acc_step)
        begin
            if (tc_reg == 3'd4)
            begin
                tc_reg <= '0;
                tr_reg <= tr_reg + 1'b1;
            end
            else
            begin
                tc_reg <= tc_reg + 1'b1;
            end
            if (tap_in)
            begin
                wsum_reg   <= wsum_reg + WSUM_W'(wtap);
                sum_reg[0] <= sum_reg[0] + SUM_W'(PROD_W'(wtap) * PROD_W'(tap[23:16]));
                sum_reg[1] <= sum_reg[1] + SUM_W'(PROD_W'(wtap) * PROD_W'(tap[15:8]));
                sum_reg[2] <= sum_reg[2] + SUM_W'(PROD_W'(wtap) * PROD_W'(tap[7:0]));
            end
        end
        else if (cmd.div_step)
        begin
            dstep_reg <= dstep_reg - 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (sum_reg[k] >= divisor)
                begin
                    sum_reg[k]             <= sum_reg[k] - divisor;
                    quot_reg[k][dstep_reg] <= 1'b1;
                end
            end
        end
    end

    // sharpen and output register
    assign centre = win_reg[2][2];
    assign last   = ((WW'(out_col_reg) + WW'(1)) >= w_eff)
                 && ((out_row_reg + 1'b1) >= h_eff);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            orig[k] = centre[23-8*k -: 8];
            blur[k] = (wsum_reg == '0) ? orig[k] : quot_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.red_out    <= gus_pkg::sharpen(orig[0], blur[0]);
            out_reg.green_out  <= gus_pkg::sharpen(orig[1], blur[1]);
            out_reg.blue_out   <= gus_pkg::sharpen(orig[2], blur[2]);
            out_reg.last_pixel <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;
    assign sts.emit     = emit_reg;
    assign sts.tap_last = (tr_reg == 3'd4) && (tc_reg == 3'd4);
    assign sts.div_last = (dstep_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule
